// ===== hw/rtl/gda_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, codes, command and status structs for the calendar date unit
// calendar tables and day serial helper; no dependencies

package gda_pkg;

    localparam int YW     = 14;   // year
    localparam int MW     = 4;    // month
    localparam int DW     = 5;    // day of month
    localparam int OFFW   = 23;   // day offset and difference
    localparam int SW     = 25;   // signed day serial working width
    localparam int DBYW   = 23;   // days before a year, unsigned
    localparam int REMW   = 9;    // day within year
    localparam int BITW   = 4;    // year search bit index
    localparam int RCPW   = 15;   // reciprocal constant width
    localparam int PRODW  = YW + RCPW;
    localparam int RECIP_SHIFT = 21;
    localparam int QW     = PRODW - RECIP_SHIFT;   // year / 100

    // floor(y / 100) = (y * RECIP100) >> RECIP_SHIFT, exact for y < 43690
    localparam logic [RCPW-1:0] RECIP100 = 15'd20972;

    localparam logic [BITW-1:0] YEAR_TOP_BIT = 4'd13;
    localparam logic [MW-1:0]   MONTH_LAST   = 4'd12;

    // serial of 0001-01-01 and of 10000-01-01
    localparam logic signed [SW-1:0] SERIAL_FIRST = 25'sd366;
    localparam logic signed [SW-1:0] SERIAL_END   = 25'sd3652425;
    localparam logic signed [SW-1:0] DIFF_HI      = 25'sd4194303;
    localparam logic signed [SW-1:0] DIFF_LO      = -25'sd4194304;

    // datapath operations
    localparam logic [2:0] DOP_NONE    = 3'd0;
    localparam logic [2:0] DOP_SAVE_SA = 3'd1;
    localparam logic [2:0] DOP_SHIFT   = 3'd2;
    localparam logic [2:0] DOP_STEP    = 3'd3;
    localparam logic [2:0] DOP_REM     = 3'd4;
    localparam logic [2:0] DOP_WALK    = 3'd5;

    // year unit source
    localparam logic [1:0] YS_A     = 2'd0;
    localparam logic [1:0] YS_B     = 2'd1;
    localparam logic [1:0] YS_CAND  = 2'd2;
    localparam logic [1:0] YS_FINAL = 2'd3;

    // result kinds
    localparam logic [1:0] RK_ERR  = 2'd0;
    localparam logic [1:0] RK_DATE = 2'd1;
    localparam logic [1:0] RK_DIFF = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       ld_year;
        logic [1:0] ysel;
        logic [2:0] dop;
        logic       res_ld;
        logic [1:0] res_kind;
        logic       out_ld;
    } gda_cmd_t;

    typedef struct packed {
        logic op;
        logic ma_bad;
        logic mb_bad;
        logic year_ok;
        logic range_bad;
        logic last_bit;
        logic month_done;
    } gda_sts_t;

    function automatic logic [8:0] cum_days(input logic [MW-1:0] m);
        logic [8:0] c;
        case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    function automatic logic [DW-1:0] month_len(input logic [MW-1:0] m, input logic leap);
        logic [DW-1:0] l;
        case (m)
            4'd2:    l = leap ? 5'd29 : 5'd28;
            4'd4:    l = 5'd30;
            4'd6:    l = 5'd30;
            4'd9:    l = 5'd30;
            4'd11:   l = 5'd30;
            default: l = 5'd31;
        endcase
        return l;
    endfunction

    // first of the month plus (day - 1), so out-of-range days roll over
    function automatic logic signed [SW-1:0] day_serial(input logic [DBYW-1:0] dby,
                                                        input logic leap,
                                                        input logic [MW-1:0] m,
                                                        input logic [DW-1:0] d);
        logic [SW-1:0] t;
        t = SW'(dby) + SW'(cum_days(m)) + SW'(leap && (m > 4'd2)) + SW'(d) - SW'(1);
        return signed'(t);
    endfunction

endpackage

// ===== hw/rtl/gregorian_date_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Gregorian date unit: shift a date by a signed day count, or subtract two dates.
// Input channel s_*, result channel m_*, both valid/ready; one result per input.
// Items are handled one at a time: s_ready is high only while the unit is idle.
// An op 1 item (A minus B) passes date A and then date B through the days-before-year
// unit and loads the difference into the result register. An op 0 item (shift A) runs
// a 14-step binary search for the year, each step a pass through the
// two-stage days-before-year unit, then a walk of up to 11 months, one a cycle.
// An invalid month of date A or of date B, or a shift that leaves years 1 to 9999,
// ends the item early with error set.
// A finished result sits in the output register until m_ready; the unit goes
// back to idle as soon as the result is loaded there, so a new input can be
// taken while the receiver stalls. A second result waits inside until the
// output register is emptied.
// Reset (aresetn low, synchronous) returns the controller to idle and drops
// m_valid; no result is pending after reset.
// depends on gda_pkg, gda_ctrl, gda_dpath

module gregorian_date_arithmetic_unit import gda_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_op,
    input  logic [YW-1:0]          s_year_a,
    input  logic [MW-1:0]          s_month_a,
    input  logic [DW-1:0]          s_day_a,
    input  logic signed [OFFW-1:0] s_offset_days,
    input  logic [YW-1:0]          s_year_b,
    input  logic [MW-1:0]          s_month_b,
    input  logic [DW-1:0]          s_day_b,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [YW-1:0]          m_res_year,
    output logic [MW-1:0]          m_res_month,
    output logic [DW-1:0]          m_res_day,
    output logic signed [OFFW-1:0] m_difference,
    output logic                   m_error
);

    gda_cmd_t cmd;
    gda_sts_t sts;

    gda_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gda_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_op          (s_op),
        .s_year_a      (s_year_a),
        .s_month_a     (s_month_a),
        .s_day_a       (s_day_a),
        .s_offset_days (s_offset_days),
        .s_year_b      (s_year_b),
        .s_month_b     (s_month_b),
        .s_day_b       (s_day_b),
        .m_res_year    (m_res_year),
        .m_res_month   (m_res_month),
        .m_res_day     (m_res_day),
        .m_difference  (m_difference),
        .m_error       (m_error)
    );

endmodule

// ===== hw/rtl/gda_year_unit.sv =====
`timescale 1ns / 1ps
// two-stage unit: days before a year and its leap flag
// depends on gda_pkg

module gda_year_unit import gda_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ld,
    input  logic [YW-1:0]   year_in,
    output logic [DBYW-1:0] dby,
    output logic            leap,
    output logic            ok
);

    logic [YW-1:0]    yq_reg;
    logic [YW-1:0]    ya_reg;
    logic [PRODW-1:0] prod_reg;
    logic [DBYW-1:0]  dby_reg;
    logic             leap_reg;
    logic             vq_reg, va_reg, vb_reg;

    logic [QW-1:0]    q;
    logic [YW-1:0]    rem_full;
    logic [6:0]       r;
    logic [YW:0]      y_plus3;
    logic [DBYW-1:0]  dby_c;
    logic             leap_c;

    always_comb begin
        q        = prod_reg[RECIP_SHIFT +: QW];
        rem_full = ya_reg - YW'(q) * YW'(100);
        r        = rem_full[6:0];
        y_plus3  = {1'b0, ya_reg} + (YW+1)'(3);
        // 365y + ceil(y/4) - ceil(y/100) + ceil(y/400)
        dby_c    = DBYW'(ya_reg) * DBYW'(365) + DBYW'(y_plus3 >> 2)
                 - DBYW'(q) - DBYW'(r != 7'd0)
                 + DBYW'(q[QW-1:2]) + DBYW'(!((r == 7'd0) && (q[1:0] == 2'd0)));
        leap_c   = ((ya_reg[1:0] == 2'd0) && (r != 7'd0))
                 || ((r == 7'd0) && (q[1:0] == 2'd0));
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            yq_reg <= year_in;
        end
        prod_reg <= PRODW'(yq_reg) * PRODW'(RECIP100);
        ya_reg   <= yq_reg;
        dby_reg  <= dby_c;
        leap_reg <= leap_c;
    end

    // a new load invalidates whatever is still in the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vq_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            vq_reg <= ld;
            va_reg <= vq_reg && !ld;
            vb_reg <= (vb_reg || va_reg) && !ld;
        end
    end

    assign dby  = dby_reg;
    assign leap = leap_reg;
    assign ok   = vb_reg;

endmodule

// ===== hw/rtl/gda_dpath.sv =====
`timescale 1ns / 1ps
// datapath: input capture, day serials, year search, month walk, result registers
// depends on gda_pkg and gda_year_unit

module gda_dpath import gda_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gda_cmd_t               cmd,
    output gda_sts_t               sts,
    input  logic                   s_op,
    input  logic [YW-1:0]          s_year_a,
    input  logic [MW-1:0]          s_month_a,
    input  logic [DW-1:0]          s_day_a,
    input  logic signed [OFFW-1:0] s_offset_days,
    input  logic [YW-1:0]          s_year_b,
    input  logic [MW-1:0]          s_month_b,
    input  logic [DW-1:0]          s_day_b,
    output logic [YW-1:0]          m_res_year,
    output logic [MW-1:0]          m_res_month,
    output logic [DW-1:0]          m_res_day,
    output logic signed [OFFW-1:0] m_difference,
    output logic                   m_error
);

    logic                   op_reg;
    logic [MW-1:0]          ma_reg, mb_reg;
    logic [DW-1:0]          da_reg, db_reg;
    logic signed [OFFW-1:0] off_reg;
    logic [YW-1:0]          yb_reg;
    logic signed [SW-1:0]   sa_reg, s_reg;
    logic [YW-1:0]          yr_reg;
    logic [BITW-1:0]        bit_reg;
    logic [REMW-1:0]        rem_reg;
    logic [MW-1:0]          mo_reg;

    logic [YW-1:0]          ry_reg;
    logic [MW-1:0]          rm_reg;
    logic [DW-1:0]          rd_reg;
    logic signed [OFFW-1:0] rdiff_reg;
    logic                   rerr_reg;

    logic [YW-1:0]          oy_reg;
    logic [MW-1:0]          om_reg;
    logic [DW-1:0]          od_reg;
    logic signed [OFFW-1:0] odiff_reg;
    logic                   oerr_reg;

    logic [YW-1:0]          year_sel;
    logic [YW-1:0]          cand;
    logic [DBYW-1:0]        dby;
    logic                   leap;
    logic                   year_ok;
    logic signed [SW-1:0]   dby_s;
    logic signed [SW-1:0]   ser_a, ser_b, s_comb, diff_c, rem_c;
    logic signed [OFFW-1:0] diff_sat;
    logic [DW-1:0]          mlen;

    assign cand = yr_reg | (YW'(1) << bit_reg);

    always_comb begin
        case (cmd.ysel)
            YS_A:     year_sel = s_year_a;
            YS_B:     year_sel = yb_reg;
            YS_CAND:  year_sel = cand;
            default:  year_sel = yr_reg;
        endcase
    end

    gda_year_unit u_year (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ld      (cmd.ld_year),
        .year_in (year_sel),
        .dby     (dby),
        .leap    (leap),
        .ok      (year_ok)
    );

    always_comb begin
        dby_s  = signed'(SW'(dby));
        ser_a  = day_serial(dby, leap, ma_reg, da_reg);
        ser_b  = day_serial(dby, leap, mb_reg, db_reg);
        s_comb = sa_reg + SW'(off_reg);
        diff_c = sa_reg - ser_b;
        rem_c  = s_reg - dby_s;
        mlen   = month_len(mo_reg, leap);
        if (diff_c > DIFF_HI) begin
            diff_sat = DIFF_HI[OFFW-1:0];
        end else if (diff_c < DIFF_LO) begin
            diff_sat = DIFF_LO[OFFW-1:0];
        end else begin
            diff_sat = diff_c[OFFW-1:0];
        end
    end

    always_comb begin
        sts.op         = op_reg;
        sts.ma_bad     = !(ma_reg inside {[4'd1:4'd12]});
        sts.mb_bad     = !(mb_reg inside {[4'd1:4'd12]});
        sts.year_ok    = year_ok;
        sts.range_bad  = (s_comb < SERIAL_FIRST) || (s_comb >= SERIAL_END);
        sts.last_bit   = (bit_reg == '0);
        sts.month_done = (mo_reg == MONTH_LAST) || (rem_reg < REMW'(mlen));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= s_op;
            ma_reg  <= s_month_a;
            da_reg  <= s_day_a;
            off_reg <= s_offset_days;
            yb_reg  <= s_year_b;
            mb_reg  <= s_month_b;
            db_reg  <= s_day_b;
        end
        case (cmd.dop)
            DOP_SAVE_SA: sa_reg <= ser_a;
            DOP_SHIFT: begin
                s_reg   <= s_comb;
                yr_reg  <= '0;
                bit_reg <= YEAR_TOP_BIT;
            end
            DOP_STEP: begin
                // keep the bit when the year starts on or before the serial
                if (dby_s <= s_reg) begin
                    yr_reg <= cand;
                end
                bit_reg <= bit_reg - BITW'(1);
            end
            DOP_REM: begin
                rem_reg <= rem_c[REMW-1:0];
                mo_reg  <= MW'(1);
            end
            DOP_WALK: begin
                rem_reg <= rem_reg - REMW'(mlen);
                mo_reg  <= mo_reg + MW'(1);
            end
            default: ;
        endcase
        if (cmd.res_ld) begin
            case (cmd.res_kind)
                RK_DATE: begin
                    ry_reg    <= yr_reg;
                    rm_reg    <= mo_reg;
                    rd_reg    <= DW'(rem_reg + REMW'(1));
                    rdiff_reg <= '0;
                    rerr_reg  <= 1'b0;
                end
                RK_DIFF: begin
                    ry_reg    <= '0;
                    rm_reg    <= '0;
                    rd_reg    <= '0;
                    rdiff_reg <= diff_sat;
                    rerr_reg  <= 1'b0;
                end
                default: begin
                    ry_reg    <= '0;
                    rm_reg    <= '0;
                    rd_reg    <= '0;
                    rdiff_reg <= '0;
                    rerr_reg  <= 1'b1;
                end
            endcase
        end
        if (cmd.out_ld) begin
            oy_reg    <= ry_reg;
            om_reg    <= rm_reg;
            od_reg    <= rd_reg;
            odiff_reg <= rdiff_reg;
            oerr_reg  <= rerr_reg;
        end
    end

    assign m_res_year   = oy_reg;
    assign m_res_month  = om_reg;
    assign m_res_day    = od_reg;
    assign m_difference = odiff_reg;
    assign m_error      = oerr_reg;

endmodule

// ===== hw/rtl/gda_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences serial computation, year search and month walk
// depends on gda_pkg; drives the datapath through gda_cmd_t

module gda_ctrl import gda_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  gda_sts_t sts,
    output gda_cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_A    = 4'd1;
    localparam logic [3:0] S_B    = 4'd2;
    localparam logic [3:0] S_SH   = 4'd3;
    localparam logic [3:0] S_SLD  = 4'd4;
    localparam logic [3:0] S_SRCH = 4'd5;
    localparam logic [3:0] S_FLD  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_WALK = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    cmd.ld_year = 1'b1;
                    cmd.ysel    = YS_A;
                    state_next  = S_A;
                end
            end
            S_A: begin
                if (sts.ma_bad) begin
                    cmd.res_ld   = 1'b1;
                    cmd.res_kind = RK_ERR;
                    state_next   = S_OUT;
                end else if (sts.year_ok) begin
                    cmd.dop = DOP_SAVE_SA;
                    if (sts.op) begin
                        cmd.ld_year = 1'b1;
                        cmd.ysel    = YS_B;
                        state_next  = S_B;
                    end else begin
                        state_next = S_SH;
                    end
                end
            end
            S_B: begin
                if (sts.mb_bad) begin
                    cmd.res_ld   = 1'b1;
                    cmd.res_kind = RK_ERR;
                    state_next   = S_OUT;
                end else if (sts.year_ok) begin
                    cmd.res_ld   = 1'b1;
                    cmd.res_kind = RK_DIFF;
                    state_next   = S_OUT;
                end
            end
            S_SH: begin
                if (sts.range_bad) begin
                    cmd.res_ld   = 1'b1;
                    cmd.res_kind = RK_ERR;
                    state_next   = S_OUT;
                end else begin
                    cmd.dop    = DOP_SHIFT;
                    state_next = S_SLD;
                end
            end
            S_SLD: begin
                cmd.ld_year = 1'b1;
                cmd.ysel    = YS_CAND;
                state_next  = S_SRCH;
            end
            S_SRCH: begin
                if (sts.year_ok) begin
                    cmd.dop    = DOP_STEP;
                    state_next = sts.last_bit ? S_FLD : S_SLD;
                end
            end
            S_FLD: begin
                cmd.ld_year = 1'b1;
                cmd.ysel    = YS_FINAL;
                state_next  = S_FIN;
            end
            S_FIN: begin
                if (sts.year_ok) begin
                    cmd.dop    = DOP_REM;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (sts.month_done) begin
                    cmd.res_ld   = 1'b1;
                    cmd.res_kind = RK_DATE;
                    state_next   = S_OUT;
                end else begin
                    cmd.dop = DOP_WALK;
                end
            end
            S_OUT: begin
                // output register free or being emptied this cycle
                if (!mvalid_reg || m_ready) begin
                    cmd.out_ld  = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mvalid_reg;

endmodule

// ===== hw/rtl/gda_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the date unit, attached by bind
// depends on gda_pkg and gregorian_date_arithmetic_unit

module gda_checker import gda_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   s_op,
    input logic [YW-1:0]          s_year_a,
    input logic [MW-1:0]          s_month_a,
    input logic [DW-1:0]          s_day_a,
    input logic signed [OFFW-1:0] s_offset_days,
    input logic [YW-1:0]          s_year_b,
    input logic [MW-1:0]          s_month_b,
    input logic [DW-1:0]          s_day_b,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [YW-1:0]          m_res_year,
    input logic [MW-1:0]          m_res_month,
    input logic [DW-1:0]          m_res_day,
    input logic signed [OFFW-1:0] m_difference,
    input logic                   m_error
);

    // waiting input holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_op) && $stable(s_year_a)
            && $stable(s_month_a) && $stable(s_day_a) && $stable(s_offset_days)
            && $stable(s_year_b) && $stable(s_month_b) && $stable(s_day_b))
        else $error("input changed while waiting");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res_year) && $stable(m_res_month)
            && $stable(m_res_day) && $stable(m_difference) && $stable(m_error))
        else $error("result changed while stalled");

    // an error result carries no date and no difference
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_res_year == '0 && m_res_month == '0
            && m_res_day == '0 && m_difference == '0)
        else $error("error result with nonzero fields");

    // a date result (nonzero year) has a month from 1 to 12, a nonzero day and no difference
    a_date_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_error && m_res_year != '0 |-> m_difference == '0
            && m_res_month >= 4'd1 && m_res_month <= MONTH_LAST && m_res_day != '0)
        else $error("malformed date result");

    // one item in flight: no input transfer right after another
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

endmodule

bind gregorian_date_arithmetic_unit gda_checker u_gda_checker (.*);
